// ----- src/crg_pkg.sv -----
// ----------------------------------------------------------------------------
// crg_pkg
// Shared types and constants of the congruential random generator.
// ----------------------------------------------------------------------------
package crg_pkg;

  // width of the generator state
  localparam int unsigned ValueWidth = 16;

  // register indexes
  localparam logic [2:0] RegMode    = 3'd0;
  localparam logic [2:0] RegModulus = 3'd1;
  localparam logic [2:0] RegMultA   = 3'd2;
  localparam logic [2:0] RegIncrC   = 3'd3;
  localparam logic [2:0] RegSquareD = 3'd4;

  // mode codes
  localparam logic [2:0] ModeLinear    = 3'd0;
  localparam logic [2:0] ModeQuadratic = 3'd1;
  localparam logic [2:0] ModeDoubling  = 3'd2;
  localparam logic [2:0] ModeInverse   = 3'd3;
  localparam logic [2:0] ModeUnion     = 3'd4;

  // op codes
  localparam logic OpAdvance = 1'b0;
  localparam logic OpLoad    = 1'b1;

  // register reset values
  localparam logic [15:0] ModulusRst = 16'd9679;
  localparam logic [15:0] MultARst   = 16'd13;
  localparam logic [15:0] IncrCRst   = 16'd190;
  localparam logic [15:0] SquareDRst = 16'd11;

  // divider request and status between sequencer and divider
  typedef struct packed {
    logic start;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- src/congruential_random_generator_core.sv -----
// ----------------------------------------------------------------------------
// congruential_random_generator_core
// Multi-mode modular pseudo-random generator with a shared divider.
// ----------------------------------------------------------------------------
// channel  direction  signals
// in       input      in_valid_i, in_ready_o, op_i, seed_i
// out      output     out_valid_o, out_ready_i, value_o, no_inverse_o
// cfg      input      cfg_we_i, cfg_idx_i, cfg_wdata_i
//
// One word at a time; each division runs on the shared divider, which
// hands its result back to the sequencer.
// Load, doubling and linear take 2 divisions, quadratic 3, union 4, spare
// mode codes 1, inverse 2 plus one per Euclid step (up to about 25).
// Reset clears the registers to their defaults and the state to 53.
// A stalled result holds in the output register; no new word until taken.
// ----------------------------------------------------------------------------
module congruential_random_generator_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [2:0]             cfg_idx_i,
  input  logic [15:0]            cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   op_i,
  input  logic [15:0]            seed_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [15:0]            value_o,
  output logic                   no_inverse_o
);

  localparam int unsigned NW = 48;
  localparam int unsigned VW = crg_pkg::ValueWidth;
  localparam logic [VW-1:0] StateRst = VW'(53);

  // sequencer states
  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StRedX  = 4'd1;  // x = state mod m
  localparam logic [3:0] StSq    = 4'd2;  // sq = x*x mod m
  localparam logic [3:0] StLin   = 4'd3;  // union result, lin+dbl mod m
  localparam logic [3:0] StDbl   = 4'd4;  // 2*lin mod m
  localparam logic [3:0] StSum   = 4'd5;  // lin+dbl mod m
  localparam logic [3:0] StEuc   = 4'd6;  // r0 / r1
  localparam logic [3:0] StInvF  = 4'd7;  // a*inv+c mod m
  localparam logic [3:0] StWait  = 4'd8;  // divider running
  localparam logic [3:0] StOut   = 4'd9;

  // configuration registers
  logic [2:0]  mode_q;
  logic [15:0] mod_q, a_q, c_q, d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= crg_pkg::ModeLinear;
      mod_q  <= crg_pkg::ModulusRst;
      a_q    <= crg_pkg::MultARst;
      c_q    <= crg_pkg::IncrCRst;
      d_q    <= crg_pkg::SquareDRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        crg_pkg::RegMode:    mode_q <= cfg_wdata_i[2:0];
        crg_pkg::RegModulus: mod_q  <= cfg_wdata_i;
        crg_pkg::RegMultA:   a_q    <= cfg_wdata_i;
        crg_pkg::RegIncrC:   c_q    <= cfg_wdata_i;
        crg_pkg::RegSquareD: d_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic [15:0] m_eff;
  assign m_eff = (mod_q < 16'd2) ? 16'd2 : mod_q;

  // sequencer registers
  logic [3:0]  st_q, st_d, ret_q, ret_d;
  logic [VW-1:0] state_q, state_d;
  logic        op_q, op_d;
  logic [15:0] seed_q, seed_d;
  logic [15:0] x_q, x_d, lin_q, lin_d;
  logic [15:0] r1_q, r1_d;
  logic signed [17:0] t0_q, t0_d, t1_q, t1_d;
  logic [15:0] res_q, res_d;
  logic        flag_q, flag_d;
  logic        ovalid_q, ovalid_d;

  // divider
  crg_pkg::div_req_t  dreq;
  crg_pkg::div_stat_t dstat;
  logic [NW-1:0] dnum, dquot;
  logic [15:0]   dden, drem;

  crg_div #(.NumWidth(NW), .DenWidth(16)) u_div (
    .clk_i, .rst_ni, .req_i(dreq), .num_i(dnum), .den_i(dden),
    .stat_o(dstat), .quot_o(dquot), .rem_o(drem)
  );

  // product terms, formed combinationally from the registers and the divider output
  logic [31:0] mul_p;
  logic [15:0] mul_a, mul_b;
  logic [31:0] ax_p;
  logic signed [35:0] qt;

  assign mul_p = mul_a * mul_b;
  assign ax_p  = a_q * x_q;
  assign qt    = $signed({2'b0, dquot[15:0]}) * t1_q;

  always_comb begin
    st_d = st_q; ret_d = ret_q; state_d = state_q; op_d = op_q; seed_d = seed_q;
    x_d = x_q; lin_d = lin_q; r1_d = r1_q;
    t0_d = t0_q; t1_d = t1_q; res_d = res_q; flag_d = flag_q; ovalid_d = ovalid_q;
    dreq.start = 1'b0; dnum = '0; dden = m_eff; mul_a = '0; mul_b = '0;
    if (ovalid_q && out_ready_i) ovalid_d = 1'b0;
    unique case (st_q)
      StIdle: begin
        if (in_valid_i && !ovalid_q) begin
          op_d = op_i; seed_d = seed_i;
          dreq.start = 1'b1;
          dnum = NW'(state_q);
          ret_d = StRedX; st_d = StWait;
        end
      end
      StWait: begin
        if (dstat.done) st_d = ret_q;
      end
      StRedX: begin
        x_d = drem; flag_d = 1'b0;
        if (op_q == crg_pkg::OpLoad) begin
          dreq.start = 1'b1; dnum = NW'(seed_q);
          ret_d = StOut; st_d = StWait;
        end else begin
          unique case (mode_q) inside
            crg_pkg::ModeLinear, crg_pkg::ModeUnion: begin
              mul_a = a_q; mul_b = drem;
              dreq.start = 1'b1; dnum = NW'(mul_p) + NW'(c_q);
              ret_d = (mode_q == crg_pkg::ModeUnion) ? StDbl : StOut; st_d = StWait;
            end
            crg_pkg::ModeQuadratic: begin
              mul_a = drem; mul_b = drem;
              dreq.start = 1'b1; dnum = NW'(mul_p);
              ret_d = StSq; st_d = StWait;
            end
            crg_pkg::ModeDoubling: begin
              dreq.start = 1'b1; dnum = NW'({drem, 1'b0});
              ret_d = StOut; st_d = StWait;
            end
            crg_pkg::ModeInverse: begin
              if (drem == 16'd0) begin
                dreq.start = 1'b1; dnum = NW'(c_q);
                ret_d = StOut; st_d = StWait;
              end else begin
                r1_d = drem; t0_d = '0; t1_d = 18'sd1;
                dreq.start = 1'b1; dnum = NW'(m_eff); dden = drem;
                ret_d = StEuc; st_d = StWait;
              end
            end
            default: begin
              res_d = drem; state_d = VW'(drem);
              ovalid_d = 1'b1; st_d = StIdle;
            end
          endcase
        end
      end
      StSq: begin
        // d*sq + a*x + c < 2^33, fits the divider numerator
        mul_a = d_q; mul_b = drem;
        dreq.start = 1'b1;
        dnum = NW'(mul_p) + NW'(ax_p) + NW'(c_q);
        ret_d = StOut; st_d = StWait;
      end
      StDbl: begin
        lin_d = drem;
        dreq.start = 1'b1; dnum = NW'({drem, 1'b0});
        ret_d = StSum; st_d = StWait;
      end
      StSum: begin
        state_d = VW'(drem);
        dreq.start = 1'b1; dnum = NW'(lin_q) + NW'(drem);
        ret_d = StLin; st_d = StWait;
      end
      StLin: begin
        res_d = drem; ovalid_d = 1'b1; st_d = StIdle;
      end
      StEuc: begin
        r1_d = drem;
        t0_d = t1_q; t1_d = t0_q - 18'(qt);
        if (drem == 16'd0) begin
          if (r1_q != 16'd1) begin
            flag_d = 1'b1; res_d = x_q; state_d = VW'(x_q);
            ovalid_d = 1'b1; st_d = StIdle;
          end else begin
            st_d = StInvF;
          end
        end else begin
          dreq.start = 1'b1; dnum = NW'(r1_q); dden = drem;
          ret_d = StEuc; st_d = StWait;
        end
      end
      StInvF: begin
        // t0 lies in (-m, m); fold into [0, m)
        mul_a = t0_q[17] ? 16'(t0_q + 18'(m_eff)) : t0_q[15:0];
        mul_b = a_q;
        dreq.start = 1'b1; dnum = NW'(mul_p) + NW'(c_q);
        ret_d = StOut; st_d = StWait;
      end
      StOut: begin
        res_d = drem; state_d = VW'(drem);
        ovalid_d = 1'b1; st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; ret_q <= StIdle; state_q <= StateRst; ovalid_q <= 1'b0;
    end else begin
      st_q <= st_d; ret_q <= ret_d; state_q <= state_d; ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; seed_q <= seed_d; x_q <= x_d; lin_q <= lin_d;
    r1_q <= r1_d; t0_q <= t0_d; t1_q <= t1_d;
    res_q <= res_d; flag_q <= flag_d;
  end

  assign in_ready_o   = (st_q == StIdle) && !ovalid_q;
  assign out_valid_o  = ovalid_q;
  assign value_o      = res_q;
  assign no_inverse_o = flag_q;

  // no new word while a result waits
  a_ready_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("ready while result pending");
  // divider is only started from a state other than wait
  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dreq.start |-> st_q != StWait) else $error("divider restarted while busy");
  // accepted word makes the block busy
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o) else $error("not busy after accept");

endmodule

// ----- src/crg_div.sv -----
// ----------------------------------------------------------------------------
// crg_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module crg_div #(
  parameter int unsigned NumWidth = 48,
  parameter int unsigned DenWidth = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  crg_pkg::div_req_t   req_i,
  input  logic [NumWidth-1:0] num_i,
  input  logic [DenWidth-1:0] den_i,
  output crg_pkg::div_stat_t  stat_o,
  output logic [NumWidth-1:0] quot_o,
  output logic [DenWidth-1:0] rem_o
);

  localparam int unsigned CntWidth = $clog2(NumWidth + 1);

  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic                busy_q, busy_d, done_q, done_d;
  logic [NumWidth-1:0] quot_q, quot_d;
  logic [DenWidth:0]   rem_q, rem_d;
  logic [DenWidth-1:0] den_q, den_d;
  logic [DenWidth:0]   trial;

  // one shift-subtract step per cycle
  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    trial  = {rem_q[DenWidth-1:0], quot_q[NumWidth-1]};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CntWidth'(NumWidth);
      quot_d = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quot_d = {quot_q[NumWidth-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quot_d = {quot_q[NumWidth-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntWidth'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quot_q;
  assign rem_o       = rem_q[DenWidth-1:0];

endmodule

// ----- bench/congruential_random_generator_core_tb.sv -----
// ----------------------------------------------------------------------------
// congruential_random_generator_core_tb
// Self-checking bench for the multi-mode congruential generator. Words go
// in through the valid/ready input channel. The scoreboard class tracks its
// own copy of the registers and of the state, and works out the expected
// word for each accepted input. Output words are checked in order, field by
// field. A directed pass covers the corner cases and random phases follow,
// each under a fresh register setting. Both channels get random gaps.
// ----------------------------------------------------------------------------
module congruential_random_generator_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 20_000_000;
  localparam int unsigned DrainCycles = 1500;
  localparam int unsigned NumPhases = 27;
  localparam int unsigned WordsPerPhase = 60;

  // mode codes with no step of their own: the state is only reduced mod m
  localparam logic [2:0] ModeSpareLo  = 3'd5;
  localparam logic [2:0] ModeSpareMid = 3'd6;
  localparam logic [2:0] ModeSpareHi  = 3'd7;

  typedef struct {
    logic [15:0] value;
    logic        no_inv;
  } gen_word_t;

  // expected-word tracker with its own register and state copy
  class crg_scoreboard;
    logic [2:0]  mode;
    logic [15:0] modulus, mult_a, incr_c, square_d, state;
    gen_word_t   expected_q[$];
    int unsigned errors;

    function new();
      mode = crg_pkg::ModeLinear;
      modulus = crg_pkg::ModulusRst;
      mult_a = crg_pkg::MultARst;
      incr_c = crg_pkg::IncrCRst;
      square_d = crg_pkg::SquareDRst;
      state = 16'd53;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] data);
      case (idx)
        crg_pkg::RegMode:    mode = data[2:0];
        crg_pkg::RegModulus: modulus = data;
        crg_pkg::RegMultA:   mult_a = data;
        crg_pkg::RegIncrC:   incr_c = data;
        crg_pkg::RegSquareD: square_d = data;
        default: ;
      endcase
    endfunction

    // extended euclid; returns 1 when x is invertible mod m
    function bit find_inverse(longint x, longint m, output longint inv);
      longint r0, r1, r2, t0, t1, t2, q;
      r0 = m; r1 = x; t0 = 0; t1 = 1;
      while (r1 != 0) begin
        q = r0 / r1;
        r2 = r0 - q * r1;
        t2 = t0 - q * t1;
        r0 = r1; r1 = r2;
        t0 = t1; t1 = t2;
      end
      inv = 0;
      if (r0 != 1) return 1'b0;
      if (t0 < 0) t0 += m;
      inv = t0 % m;
      return 1'b1;
    endfunction

    // next state and output word for one accepted input word
    function void note_input(logic op, logic [15:0] seed);
      longint m, x, a, c, d, res, inv, lin, dbl;
      gen_word_t w;
      m = (modulus < 2) ? 2 : modulus;
      x = state % m;
      a = mult_a; c = incr_c; d = square_d;
      w.no_inv = 1'b0;
      if (op == crg_pkg::OpLoad) begin
        x = seed % m;
        res = x;
      end else begin
        case (mode)
          crg_pkg::ModeLinear:    x = (a * x + c) % m;
          crg_pkg::ModeQuadratic: x = (d * ((x * x) % m) + a * x + c) % m;
          crg_pkg::ModeDoubling:  x = (x + x) % m;
          crg_pkg::ModeInverse: begin
            if (x == 0) x = c % m;
            else if (find_inverse(x, m, inv)) x = (a * inv + c) % m;
            else w.no_inv = 1'b1;
          end
          default: ;
        endcase
        res = x;
        if (mode == crg_pkg::ModeUnion) begin
          lin = (a * (state % m) + c) % m;
          dbl = (lin + lin) % m;
          x = dbl;
          res = (lin + dbl) % m;
        end
      end
      state = x[15:0];
      w.value = res[15:0];
      expected_q.push_back(w);
    endfunction

    function void check_result(logic [15:0] value, logic no_inv);
      gen_word_t w;
      if (expected_q.size() == 0) begin
        $error("unexpected output word: value %0d no_inverse %0d", value, no_inv);
        errors++;
        return;
      end
      w = expected_q.pop_front();
      if (value !== w.value) begin
        $error("value: expected %0d, got %0d", w.value, value);
        errors++;
      end
      if (no_inv !== w.no_inv) begin
        $error("no_inverse: expected %0d, got %0d", w.no_inv, no_inv);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = crg_pkg::RegMode;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        op_i = crg_pkg::OpAdvance;
  logic [15:0] seed_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] value_o;
  logic        no_inverse_o;

  crg_scoreboard sb = new();
  int unsigned cycle_cnt = 0;
  bit          no_gaps = 1'b0;
  logic [15:0] primes[6] = '{16'd2, 16'd3, 16'd251, 16'd7919, 16'd32749, 16'd65521};

  congruential_random_generator_core dut (.*);

  // clock
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // timeout
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [15:0] rand_field();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'd0;
    if (r == 1) return 16'hffff;
    return 16'($urandom());
  endfunction

  // output side: random stalls, then check each taken word
  initial begin
    int unsigned stall;
    stall = 0;
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        out_ready_i = 1'b0;
        stall--;
      end else begin
        out_ready_i = 1'b1;
        stall = gap_len();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(value_o, no_inverse_o);
  end

  // send one word, held until accepted
  task automatic send_word(logic op, logic [15:0] seed);
    int unsigned gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    op_i = op;
    seed_i = seed;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(op, seed);
    @(negedge clk_i);
  endtask

  // wait until all words are back, then write a register
  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    in_valid_i = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = data;
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_all(logic [2:0] mode, logic [15:0] m, logic [15:0] a,
                         logic [15:0] c, logic [15:0] d);
    write_reg(crg_pkg::RegMode, {13'd0, mode});
    write_reg(crg_pkg::RegModulus, m);
    write_reg(crg_pkg::RegMultA, a);
    write_reg(crg_pkg::RegIncrC, c);
    write_reg(crg_pkg::RegSquareD, d);
  endtask

  initial begin
    logic [2:0] mode;
    logic [15:0] m;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: reset settings first, then every mode at the extremes
    send_word(crg_pkg::OpAdvance, 16'd0);
    send_word(crg_pkg::OpLoad, 16'hffff);
    send_word(crg_pkg::OpLoad, 16'd0);
    set_all(crg_pkg::ModeQuadratic, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_word(crg_pkg::OpLoad, 16'hfffe);
    send_word(crg_pkg::OpAdvance, 16'd0);
    write_reg(crg_pkg::RegMode, {13'd0, crg_pkg::ModeDoubling});
    send_word(crg_pkg::OpAdvance, 16'd0);
    write_reg(crg_pkg::RegMode, {13'd0, crg_pkg::ModeUnion});
    send_word(crg_pkg::OpAdvance, 16'd0);
    // state above a lowered modulus
    write_reg(crg_pkg::RegModulus, 16'd7);
    send_word(crg_pkg::OpAdvance, 16'd0);
    // modulus of zero and one act as two
    write_reg(crg_pkg::RegModulus, 16'd0);
    send_word(crg_pkg::OpAdvance, 16'd0);
    write_reg(crg_pkg::RegModulus, 16'd1);
    send_word(crg_pkg::OpLoad, 16'd5);
    // inverse mode: zero state, invertible state, no inverse
    set_all(crg_pkg::ModeInverse, 16'd10, 16'd3, 16'd7, 16'd0);
    send_word(crg_pkg::OpLoad, 16'd0);
    send_word(crg_pkg::OpAdvance, 16'd0);
    send_word(crg_pkg::OpAdvance, 16'd0);
    send_word(crg_pkg::OpLoad, 16'd4);
    send_word(crg_pkg::OpAdvance, 16'd0);
    write_reg(crg_pkg::RegModulus, 16'd65521);
    send_word(crg_pkg::OpLoad, 16'd65520);
    send_word(crg_pkg::OpAdvance, 16'd0);
    // spare mode codes only reduce the state mod m
    write_reg(crg_pkg::RegMode, {13'd0, ModeSpareLo});
    send_word(crg_pkg::OpAdvance, 16'd0);
    write_reg(crg_pkg::RegMode, {13'd0, ModeSpareHi});
    send_word(crg_pkg::OpAdvance, 16'd0);
    write_reg(crg_pkg::RegMode, {13'd0, ModeSpareMid});
    send_word(crg_pkg::OpAdvance, 16'd0);

    // random phases, each under a new register setting
    for (int p = 0; p < NumPhases; p++) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      mode = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                         : 3'($urandom_range(0, 4));
      if (mode == crg_pkg::ModeInverse && $urandom_range(0, 3) != 0)
        m = primes[$urandom_range(0, 5)];
      else if ($urandom_range(0, 5) == 0)
        m = 16'($urandom_range(0, 3));
      else
        m = rand_field();
      set_all(mode, m, rand_field(), rand_field(), rand_field());
      for (int i = 0; i < WordsPerPhase; i++) begin
        if ($urandom_range(0, 99) < 15) send_word(crg_pkg::OpLoad, rand_field());
        else send_word(crg_pkg::OpAdvance, 16'($urandom()));
      end
    end
    in_valid_i = 1'b0;

    // drain
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
